/* rtl/core/eah_pkg.sv */
`timescale 1ns / 1ps
// eah_pkg: shared constants, types and helper functions of the escape angle histogram.
// Used by every module under rtl/core. No dependencies.
package eah_pkg;

   localparam int WAVELENGTHS     = 16;
   localparam int MAX_BINS        = 64;
   localparam int ANGLE_FRAC_BITS = 16;

   localparam int WL_W     = 4;
   localparam int SEL_W    = 6;
   localparam int DIR_W    = 16;
   localparam int Y_W      = 32;
   localparam int MAG_W    = 16;
   localparam int VAL_W    = 40;
   localparam int BCREG_W  = 7;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 1;

   localparam int HIST_DEPTH = WAVELENGTHS * MAX_BINS;
   localparam int HA_W       = $clog2(HIST_DEPTH);
   localparam int BIN_W      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int BCNT_W     = $clog2(MAX_BINS + 1);

   localparam int COORD_SHIFT = 16;
   localparam int XY_W        = 36;
   localparam int Z_W         = ANGLE_FRAC_BITS + 2;
   localparam int ANG_W       = ANGLE_FRAC_BITS + 1;
   localparam int PROD_W      = ANG_W + BCNT_W;

   localparam int TABLE_LEN     = 27;
   localparam int TBL_IW        = $clog2(TABLE_LEN);
   localparam int CORDIC_STEPS  = (ANGLE_FRAC_BITS + 2 > TABLE_LEN) ?
                                  TABLE_LEN : ANGLE_FRAC_BITS + 2;
   localparam int SC_W          = $clog2(CORDIC_STEPS);

   // atan(2^-i)/pi, Q0.32
   localparam logic [31:0] ATAN_HT [TABLE_LEN] = '{
      32'd1073741824, 32'd633866811, 32'd334917814, 32'd170009512, 32'd85334662,
      32'd42708931, 32'd21359677, 32'd10680490, 32'd5340327, 32'd2670173,
      32'd1335088, 32'd667544, 32'd333772, 32'd166886, 32'd83443,
      32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
      32'd1304, 32'd652, 32'd326, 32'd163, 32'd81,
      32'd41, 32'd20
   };

   typedef enum logic [1:0] {
      ACT_RECORD = 2'd0,
      ACT_CLEAR  = 2'd1,
      ACT_READ   = 2'd2
   } action_type;

   localparam logic KIND_TOTAL = 1'b0;
   localparam logic KIND_BIN   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_LEVEL = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_COUNT    = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      HOP_ADD   = 2'd0,
      HOP_READ  = 2'd1,
      HOP_CLEAR = 2'd2
   } hist_op_type;

   typedef struct packed {
      logic              valid;
      hist_op_type       op;
      logic [HA_W-1:0]   addr;
      logic [MAG_W-1:0]  mag;
   } hist_cmd_type;

   typedef struct packed {
      logic ready;
      logic done;
   } hist_stat_type;

   function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                input logic [MAG_W-1:0] b);
      logic [VAL_W:0] sum;
      sum = {1'b0, a} + (VAL_W+1)'(b);
      return sum[VAL_W] ? {VAL_W{1'b1}} : sum[VAL_W-1:0];
   endfunction

   function automatic logic [Z_W-1:0] atan_step(input logic [TBL_IW-1:0] idx);
      logic [32:0] sum;
      sum = {1'b0, ATAN_HT[idx]} + (33'd1 << (31 - ANGLE_FRAC_BITS));
      return Z_W'(sum >> (32 - ANGLE_FRAC_BITS));
   endfunction

endpackage

/* rtl/core/eah_cordic.sv */
`timescale 1ns / 1ps
// eah_cordic: iterative CORDIC vectoring unit, one step per cycle.
// Gives the direction angle as a fraction of 180 degrees. Depends on eah_pkg.
module eah_cordic
   import eah_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DIR_W-1:0] dir_x,
   input  logic signed [DIR_W-1:0] dir_y,
   output logic                    done,
   output logic [ANG_W-1:0]        angle
);

   localparam logic signed [Z_W-1:0] Z_ONE  = Z_W'(1 << ANGLE_FRAC_BITS);
   localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(1 << (ANGLE_FRAC_BITS - 1));

   logic                   run_ff, run_in;
   logic [SC_W-1:0]        cnt_ff, cnt_in;
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;

   logic [DIR_W:0]         dy_abs;
   logic signed [XY_W-1:0] x0, y0, xs, ys;
   logic [Z_W-1:0]         step;

   assign dy_abs = dir_y[DIR_W-1] ? ((DIR_W+1)'(0) - {dir_y[DIR_W-1], dir_y})
                                  : {1'b0, dir_y};
   assign x0   = XY_W'(dir_x) <<< COORD_SHIFT;
   assign y0   = XY_W'(dy_abs) << COORD_SHIFT;
   assign xs   = x_ff >>> cnt_ff;
   assign ys   = y_ff >>> cnt_ff;
   assign step = atan_step(TBL_IW'(cnt_ff));
   assign done = run_ff && (cnt_ff == SC_W'(CORDIC_STEPS - 1));

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         if (x0 < 0) begin
            // turn by -90 degrees so the loop starts in the right half plane
            x_in = y0;
            y_in = -x0;
            z_in = Z_HALF;
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (run_ff) begin
         cnt_in = cnt_ff + SC_W'(1);
         if (done) begin
            run_in = 1'b0;
         end
         if (!y_ff[XY_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + $signed(step);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - $signed(step);
         end
      end
   end

   always_comb begin
      if (z_ff < 0) begin
         angle = '0;
      end else if (z_ff > Z_ONE) begin
         angle = Z_ONE[ANG_W-1:0];
      end else begin
         angle = z_ff[ANG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

endmodule

/* rtl/core/eah_hist.sv */
`timescale 1ns / 1ps
// eah_hist: histogram store with saturating read-modify-write, bin read and row clear.
// Sweeps the whole memory to zero after reset. Depends on eah_pkg.
module eah_hist
   import eah_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  hist_cmd_type      cmd,
   output hist_stat_type     stat,
   output logic [VAL_W-1:0]  rd_data
);

   typedef enum logic [3:0] {
      H_INIT   = 4'b0001,
      H_IDLE   = 4'b0010,
      H_ACCESS = 4'b0100,
      H_CLEAR  = 4'b1000
   } hstate_type;

   logic [VAL_W-1:0] mem [HIST_DEPTH];

   hstate_type       state_ff, state_in;
   logic [HA_W-1:0]  ptr_ff, ptr_in;
   logic [HA_W-1:0]  addr_ff;
   hist_op_type      op_ff;
   logic [MAG_W-1:0] mag_ff;
   logic [VAL_W-1:0] rd_data_ff;

   logic             rd_en, wr_en;
   logic [HA_W-1:0]  wr_addr;
   logic [VAL_W-1:0] wr_data;
   logic             clr_last;

   assign rd_en    = (state_ff == H_IDLE) && cmd.valid;
   assign clr_last = (ptr_ff == addr_ff + HA_W'(MAX_BINS - 1));
   assign rd_data  = rd_data_ff;

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      wr_en      = 1'b0;
      wr_addr    = ptr_ff;
      wr_data    = '0;
      stat.ready = 1'b0;
      stat.done  = 1'b0;
      case (state_ff)
         H_INIT: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + HA_W'(1);
            if (ptr_ff == HA_W'(HIST_DEPTH - 1)) begin
               state_in = H_IDLE;
            end
         end
         H_IDLE: begin
            stat.ready = 1'b1;
            if (cmd.valid) begin
               ptr_in = cmd.addr;
               if (cmd.op == HOP_CLEAR) begin
                  state_in = H_CLEAR;
               end else begin
                  state_in = H_ACCESS;
               end
            end
         end
         H_ACCESS: begin
            stat.done = 1'b1;
            state_in  = H_IDLE;
            if (op_ff == HOP_ADD) begin
               wr_en   = 1'b1;
               wr_addr = addr_ff;
               wr_data = sat_add(rd_data_ff, mag_ff);
            end
         end
         H_CLEAR: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + HA_W'(1);
            if (clr_last) begin
               stat.done = 1'b1;
               state_in  = H_IDLE;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_INIT;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         addr_ff <= cmd.addr;
         op_ff   <= cmd.op;
         mag_ff  <= cmd.mag;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

endmodule

/* rtl/core/escape_angle_histogram_top.sv */
`timescale 1ns / 1ps
// escape_angle_histogram_top: sequencer, config registers, batch total and result register.
// Instantiates eah_cordic and eah_hist; depends on eah_pkg.
//
// Usage: one request beat at a time on req_* (valid/stall). Action record adds a counted
// ray's magnitude to its angle bin and to the batch total; on last_ray a beat of kind 0
// carries the total, which is then cleared. Action clear zeroes one wavelength row and
// returns nothing. Action read returns a beat of kind 1 with the bin value.
// Path from accept to result: a counted ray with a nonzero direction runs the 18-step
// CORDIC loop (one shift-add step per cycle), then scale, issue, memory access and finish;
// reads and counted zero-direction rays go through issue, memory access and finish; other
// rays go straight to finish. A row clear walks 64 bins and keeps the block busy meanwhile.
// The block works on one item at a time and holds req_stall high until it is finished, so
// the next beat is taken only after the previous item has ended.
// Reset: synchronous. Afterwards the histogram memory is swept to zero, one entry per
// cycle, all 1024 entries, while req_stall stays high; csr writes are taken throughout.
// A finished result sits in the rsp register; the next request is accepted while it waits.
// If rsp_stall holds a result, a following item that has a result waits before finishing.
module escape_angle_histogram_top
   import eah_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_action,
   input  logic [WL_W-1:0]         req_wavelength,
   input  logic [SEL_W-1:0]        req_bin_select,
   input  logic                    req_ray_done,
   input  logic signed [Y_W-1:0]   req_end_y,
   input  logic signed [DIR_W-1:0] req_dir_x,
   input  logic signed [DIR_W-1:0] req_dir_y,
   input  logic [MAG_W-1:0]        req_magnitude,
   input  logic                    req_last_ray,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_kind,
   output logic [VAL_W-1:0]        rsp_value,
   output logic [SEL_W-1:0]        rsp_bin_index,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_data
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_ANGLE  = 6'b000010,
      S_SCALE  = 6'b000100,
      S_ISSUE  = 6'b001000,
      S_WAIT   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic signed [Y_W-1:0]  escape_level_ff;
   logic [BCREG_W-1:0]     bin_count_ff;
   logic [VAL_W-1:0]       total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff;
   logic [VAL_W-1:0]       rsp_value_ff;
   logic [SEL_W-1:0]       rsp_bin_index_ff;

   logic [1:0]             action_ff;
   logic [WL_W-1:0]        wl_ff;
   logic [SEL_W-1:0]       sel_ff;
   logic [MAG_W-1:0]       mag_ff;
   logic                   last_ff;
   logic                   counted_ff;
   logic                   vec_zero_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [VAL_W-1:0]       value_ff;

   logic                   accept, counted, vec_zero, cordic_start, cordic_done;
   logic [ANG_W-1:0]       angle;
   logic [BCNT_W-1:0]      count_eff;
   logic [PROD_W-ANGLE_FRAC_BITS-1:0] bin_raw;
   logic [BIN_W-1:0]       bin_sel;
   logic                   row_ok, sel_ok, issue_go;
   logic [HA_W-1:0]        row_base;
   logic                   has_result, slot_free, leave;
   logic [VAL_W-1:0]       rec_sum;
   hist_cmd_type           hist_cmd;
   hist_stat_type          hist_stat;
   logic [VAL_W-1:0]       hist_rd_data;

   assign accept    = req_valid && !req_stall;
   assign req_stall = !((state_ff == S_IDLE) && hist_stat.ready);
   assign counted   = (req_action == ACT_RECORD) && req_ray_done &&
                      (req_end_y < escape_level_ff);
   assign vec_zero  = (req_dir_x == '0) && (req_dir_y == '0);
   assign cordic_start = accept && counted && !vec_zero;

   always_comb begin
      if (bin_count_ff == '0) begin
         count_eff = BCNT_W'(1);
      end else if (int'(bin_count_ff) > MAX_BINS) begin
         count_eff = BCNT_W'(MAX_BINS);
      end else begin
         count_eff = BCNT_W'(bin_count_ff);
      end
   end

   assign bin_raw = prod_ff[PROD_W-1:ANGLE_FRAC_BITS];

   always_comb begin
      if (vec_zero_ff) begin
         bin_sel = '0;
      end else if (bin_raw >= (PROD_W-ANGLE_FRAC_BITS)'(count_eff)) begin
         bin_sel = BIN_W'(count_eff - BCNT_W'(1));
      end else begin
         bin_sel = BIN_W'(bin_raw);
      end
   end

   assign row_ok   = int'(wl_ff) < WAVELENGTHS;
   assign sel_ok   = int'(sel_ff) < MAX_BINS;
   assign row_base = HA_W'(int'(wl_ff) * MAX_BINS);

   always_comb begin
      hist_cmd.valid = 1'b0;
      hist_cmd.op    = HOP_ADD;
      hist_cmd.addr  = row_base;
      hist_cmd.mag   = mag_ff;
      issue_go       = 1'b0;
      case (action_ff)
         ACT_RECORD: begin
            issue_go      = row_ok;
            hist_cmd.addr = row_base + HA_W'(bin_sel);
         end
         ACT_CLEAR: begin
            issue_go    = row_ok;
            hist_cmd.op = HOP_CLEAR;
         end
         ACT_READ: begin
            issue_go      = row_ok && sel_ok;
            hist_cmd.op   = HOP_READ;
            hist_cmd.addr = row_base + HA_W'(sel_ff);
         end
         default: begin
            issue_go = 1'b0;
         end
      endcase
      hist_cmd.valid = (state_ff == S_ISSUE) && issue_go;
   end

   assign has_result = ((action_ff == ACT_RECORD) && last_ff) || (action_ff == ACT_READ);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign leave      = !has_result || slot_free;
   assign rec_sum    = sat_add(total_ff, counted_ff ? mag_ff : MAG_W'(0));

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (cordic_start) begin
                  state_in = S_ANGLE;
               end else if (counted || (req_action == ACT_CLEAR) ||
                            (req_action == ACT_READ)) begin
                  state_in = S_ISSUE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_ANGLE: begin
            if (cordic_done) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            state_in = issue_go ? S_WAIT : S_FINISH;
         end
         S_WAIT: begin
            if (hist_stat.done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (leave) begin
               state_in = S_IDLE;
               if (has_result) begin
                  rsp_valid_in = 1'b1;
               end
               if (action_ff == ACT_RECORD) begin
                  total_in = last_ff ? '0 : rec_sum;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         total_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         escape_level_ff <= '0;
         bin_count_ff    <= BCREG_W'(64);
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && (csr_index == CSR_ESCAPE_LEVEL)) begin
            escape_level_ff <= csr_data;
         end
         if (csr_write && (csr_index == CSR_BIN_COUNT)) begin
            bin_count_ff <= csr_data[BCREG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= req_action;
         wl_ff       <= req_wavelength;
         sel_ff      <= req_bin_select;
         mag_ff      <= req_magnitude;
         last_ff     <= req_last_ray;
         counted_ff  <= counted;
         vec_zero_ff <= vec_zero;
      end
      if (state_ff == S_SCALE) begin
         prod_ff <= PROD_W'(angle) * PROD_W'(count_eff);
      end
      if (state_ff == S_ISSUE) begin
         value_ff <= '0;
      end
      if ((state_ff == S_WAIT) && hist_stat.done) begin
         value_ff <= hist_rd_data;
      end
      if ((state_ff == S_FINISH) && leave && has_result) begin
         if (action_ff == ACT_READ) begin
            rsp_kind_ff      <= KIND_BIN;
            rsp_value_ff     <= value_ff;
            rsp_bin_index_ff <= sel_ff;
         end else begin
            rsp_kind_ff      <= KIND_TOTAL;
            rsp_value_ff     <= rec_sum;
            rsp_bin_index_ff <= '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_bin_index = rsp_bin_index_ff;

   eah_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .dir_x (req_dir_x),
      .dir_y (req_dir_y),
      .done  (cordic_done),
      .angle (angle)
   );

   eah_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (hist_cmd),
      .stat    (hist_stat),
      .rd_data (hist_rd_data)
   );

endmodule

/* rtl/core/eah_checker.sv */
`timescale 1ns / 1ps
// eah_checker: port-level assertions for escape_angle_histogram_top, bound to the top level.
// Depends on eah_pkg.
module eah_checker
   import eah_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_kind,
   input logic [VAL_W-1:0]        rsp_value,
   input logic [SEL_W-1:0]        rsp_bin_index
);

   // one item at a time: an accepted beat blocks the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted back to back");

   // memory sweep after reset keeps the input closed
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request open right after reset");

   // a new result only comes from an item in flight
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no item in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_value) &&
                                    $stable(rsp_kind) && $stable(rsp_bin_index)))
      else $error("stalled result beat changed");

   a_total_bin_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_TOTAL)) |-> (rsp_bin_index == '0))
      else $error("batch total beat with nonzero bin index");

endmodule

bind escape_angle_histogram_top eah_checker u_eah_checker (.*);
